FILE: design/scp_pkg.sv
package scp_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int ARG_LIMIT     = 8;
  localparam int NAME_CAPACITY = 8;

  localparam int BYTE_W     = 8;
  localparam int NAME_BYTES = 7;
  localparam int NAME_W     = NAME_BYTES * BYTE_W;
  localparam int NAME_LEN_W = 3;
  localparam int ARG_SLOTS  = 8;
  localparam int ARG_IDX_W  = 3;
  localparam int ARG_W      = 31;
  localparam int CNT_W      = 4;
  localparam int ENTRIES    = 3;
  localparam int IDX_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int REG_W      = 3;
  localparam int DATA_W     = NAME_W;

  localparam logic [NAME_LEN_W-1:0] NAME_MAX = NAME_LEN_W'(NAME_CAPACITY - 1);
  localparam logic [LEN_W-1:0]      LEN_LAST = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [ARG_W-1:0]      ARG_MAX  = {ARG_W{1'b1}};

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd2;

  localparam logic [REG_W-1:0] REG_ENTRY0_NAME  = 3'd0;
  localparam logic [REG_W-1:0] REG_ENTRY0_COUNT = 3'd1;
  localparam logic [REG_W-1:0] REG_ENTRY1_NAME  = 3'd2;
  localparam logic [REG_W-1:0] REG_ENTRY1_COUNT = 3'd3;
  localparam logic [REG_W-1:0] REG_ENTRY2_NAME  = 3'd4;
  localparam logic [REG_W-1:0] REG_ENTRY2_COUNT = 3'd5;

  localparam logic [NAME_W-1:0] ENTRY0_NAME_RST  = NAME_W'(99);
  localparam logic [NAME_W-1:0] ENTRY1_NAME_RST  = NAME_W'(108);
  localparam logic [NAME_W-1:0] ENTRY2_NAME_RST  = NAME_W'(98);
  localparam logic [CNT_W-1:0]  ENTRY0_COUNT_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0]  ENTRY1_COUNT_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0]  ENTRY2_COUNT_RST = CNT_W'(2);

  typedef struct packed {
    logic [ENTRIES-1:0][NAME_W-1:0] name;
    logic [ENTRIES-1:0][CNT_W-1:0]  count;
  } cfg_t;

  typedef struct packed {
    logic [NAME_W-1:0]                name;
    logic [CNT_W-1:0]                 total;
    logic [ARG_SLOTS-1:0][ARG_W-1:0]  args;
  } line_t;

endpackage

FILE: design/scp_parse.sv
module scp_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [scp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        term,
  output scp_pkg::line_t              line
);

  logic [scp_pkg::LEN_W-1:0]      line_length, line_length_next;
  logic                           in_name_phase, in_name_phase_next;
  logic [scp_pkg::NAME_W-1:0]     name_bytes, name_bytes_next;
  logic [scp_pkg::NAME_LEN_W-1:0] name_length, name_length_next;
  logic                           content_ended, content_ended_next;
  logic                           in_digit_run, in_digit_run_next;
  logic [scp_pkg::CNT_W-1:0]      args_found, args_found_next;
  logic [scp_pkg::ARG_W-1:0]      acc, acc_next;
  logic [scp_pkg::ARG_SLOTS-1:0][scp_pkg::ARG_W-1:0] store;

  logic                           restart;
  logic                           wr_en;
  logic [scp_pkg::ARG_IDX_W-1:0]  wr_idx;
  logic [scp_pkg::ARG_W-1:0]      wr_val;
  logic                           take_arg;
  logic                           is_digit;
  logic [scp_pkg::ARG_W-1:0]      digit;
  logic [scp_pkg::ARG_W+3:0]      acc_wide;
  logic [scp_pkg::ARG_W-1:0]      acc_sat;
  logic [scp_pkg::CNT_W-1:0]      run_idx;

  assign term     = (rx_byte == scp_pkg::CHAR_CR) || (rx_byte == scp_pkg::CHAR_LF);
  assign is_digit = (rx_byte >= scp_pkg::CHAR_ZERO) && (rx_byte <= scp_pkg::CHAR_NINE);
  assign digit    = scp_pkg::ARG_W'(rx_byte - scp_pkg::CHAR_ZERO);

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, clipped to the 31-bit max
  assign acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {4'b0, digit};
  assign acc_sat  = (acc_wide > {4'b0, scp_pkg::ARG_MAX}) ? scp_pkg::ARG_MAX
                                                          : acc_wide[scp_pkg::ARG_W-1:0];
  assign run_idx  = args_found - scp_pkg::CNT_W'(1);

  always_comb begin
    line_length_next   = line_length;
    in_name_phase_next = in_name_phase;
    name_bytes_next    = name_bytes;
    name_length_next   = name_length;
    content_ended_next = content_ended;
    in_digit_run_next  = in_digit_run;
    args_found_next    = args_found;
    acc_next           = acc;
    restart            = 1'b0;
    wr_en              = 1'b0;
    wr_idx             = '0;
    wr_val             = '0;
    take_arg           = 1'b0;
    if (advance) begin
      if (term || (line_length >= scp_pkg::LEN_LAST)) begin
        restart = 1'b1;
      end else begin
        line_length_next = line_length + scp_pkg::LEN_W'(1);
        if (!content_ended) begin
          take_arg = 1'b1;
          if (in_name_phase) begin
            if ((rx_byte != scp_pkg::CHAR_NUL) && !is_digit &&
                (rx_byte != scp_pkg::CHAR_COMMA) && (name_length < scp_pkg::NAME_MAX)) begin
              for (int k = 0; k < scp_pkg::NAME_BYTES; k++) begin
                if (name_length == scp_pkg::NAME_LEN_W'(k))
                  name_bytes_next[k*scp_pkg::BYTE_W +: scp_pkg::BYTE_W] = rx_byte;
              end
              name_length_next = name_length + scp_pkg::NAME_LEN_W'(1);
              take_arg = 1'b0;
            end else begin
              in_name_phase_next = 1'b0;
            end
          end
          if (take_arg) begin
            if (rx_byte == scp_pkg::CHAR_NUL) begin
              content_ended_next = 1'b1;
              in_digit_run_next  = 1'b0;
            end else if (is_digit) begin
              if (in_digit_run) begin
                wr_en    = 1'b1;
                wr_idx   = run_idx[scp_pkg::ARG_IDX_W-1:0];
                wr_val   = acc_sat;
                acc_next = acc_sat;
              end else if (args_found < scp_pkg::CNT_W'(scp_pkg::ARG_LIMIT)) begin
                wr_en             = 1'b1;
                wr_idx            = args_found[scp_pkg::ARG_IDX_W-1:0];
                wr_val            = digit;
                acc_next          = digit;
                args_found_next   = args_found + scp_pkg::CNT_W'(1);
                in_digit_run_next = 1'b1;
              end
            end else begin
              in_digit_run_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      line_length   <= '0;
      in_name_phase <= 1'b1;
      name_bytes    <= '0;
      name_length   <= '0;
      content_ended <= 1'b0;
      in_digit_run  <= 1'b0;
      args_found    <= '0;
      store         <= '0;
    end else begin
      line_length   <= line_length_next;
      in_name_phase <= in_name_phase_next;
      name_bytes    <= name_bytes_next;
      name_length   <= name_length_next;
      content_ended <= content_ended_next;
      in_digit_run  <= in_digit_run_next;
      args_found    <= args_found_next;
      if (wr_en)
        store[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  assign line.name  = name_bytes;
  assign line.total = args_found;
  assign line.args  = store;

endmodule

FILE: design/scp_match.sv
module scp_match (
  input  scp_pkg::cfg_t                 cfg,
  input  scp_pkg::line_t                line,
  output logic [scp_pkg::STATUS_W-1:0]  status,
  output logic [scp_pkg::IDX_W-1:0]     command_index
);

  logic [scp_pkg::ENTRIES-1:0][scp_pkg::NAME_W-1:0] eff;
  logic [scp_pkg::ENTRIES-1:0]                      live;
  logic [scp_pkg::ENTRIES-1:0]                      hit;
  logic                                             keep;
  logic                                             found;

  // name is taken up to its first zero byte; an empty entry ends the table
  always_comb begin
    for (int e = 0; e < scp_pkg::ENTRIES; e++) begin
      keep   = 1'b1;
      eff[e] = '0;
      for (int k = 0; k < scp_pkg::NAME_BYTES; k++) begin
        keep = keep && (cfg.name[e][k*scp_pkg::BYTE_W +: scp_pkg::BYTE_W] != scp_pkg::CHAR_NUL);
        if (keep)
          eff[e][k*scp_pkg::BYTE_W +: scp_pkg::BYTE_W] =
            cfg.name[e][k*scp_pkg::BYTE_W +: scp_pkg::BYTE_W];
      end
    end
    for (int e = 0; e < scp_pkg::ENTRIES; e++) begin
      live[e] = (eff[e][scp_pkg::BYTE_W-1:0] != scp_pkg::CHAR_NUL);
      if (e > 0)
        live[e] = live[e] && live[e-1];
      hit[e] = live[e] && (eff[e] == line.name);
    end
    status        = scp_pkg::ST_UNKNOWN;
    command_index = '0;
    found         = 1'b0;
    for (int e = 0; e < scp_pkg::ENTRIES; e++) begin
      if (hit[e] && !found) begin
        found         = 1'b1;
        command_index = scp_pkg::IDX_W'(e);
        status        = (cfg.count[e] == line.total) ? scp_pkg::ST_OK
                                                     : scp_pkg::ST_BAD_COUNT;
      end
    end
  end

endmodule

FILE: design/serial_command_line_parser_top.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     rx_byte
// result    out_valid / out_ready   status, command_index, argument_total, arg0..arg7
// config    cfg_write (no wait)     cfg_index, cfg_data
//
// One byte per cycle while in_ready is high: a byte is held in the input register,
// then the line state and, on CR or LF, the result register are updated in one pass.
// out_valid is registered and is set at the edge at which a line end leaves the input register.
// in_ready drops only while a line end waits in the input register behind an
// untaken result; other bytes keep flowing under a stalled output.
// rst is synchronous: line state restarts empty and the table takes its defaults.
module serial_command_line_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [scp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scp_pkg::STATUS_W-1:0]  status,
  output logic [scp_pkg::IDX_W-1:0]     command_index,
  output logic [scp_pkg::CNT_W-1:0]     argument_total,
  output logic [scp_pkg::ARG_W-1:0]     arg0,
  output logic [scp_pkg::ARG_W-1:0]     arg1,
  output logic [scp_pkg::ARG_W-1:0]     arg2,
  output logic [scp_pkg::ARG_W-1:0]     arg3,
  output logic [scp_pkg::ARG_W-1:0]     arg4,
  output logic [scp_pkg::ARG_W-1:0]     arg5,
  output logic [scp_pkg::ARG_W-1:0]     arg6,
  output logic [scp_pkg::ARG_W-1:0]     arg7,
  input  logic                          cfg_write,
  input  logic [scp_pkg::REG_W-1:0]     cfg_index,
  input  logic [scp_pkg::DATA_W-1:0]    cfg_data
);

  scp_pkg::cfg_t                 cfg;
  scp_pkg::line_t                line;
  logic                          buf_valid;
  logic [scp_pkg::BYTE_W-1:0]    buf_byte;
  logic                          term;
  logic                          advance;
  logic [scp_pkg::STATUS_W-1:0]  match_status;
  logic [scp_pkg::IDX_W-1:0]     match_index;
  logic [scp_pkg::ARG_SLOTS-1:0][scp_pkg::ARG_W-1:0] out_args;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.name[0]  <= scp_pkg::ENTRY0_NAME_RST;
      cfg.name[1]  <= scp_pkg::ENTRY1_NAME_RST;
      cfg.name[2]  <= scp_pkg::ENTRY2_NAME_RST;
      cfg.count[0] <= scp_pkg::ENTRY0_COUNT_RST;
      cfg.count[1] <= scp_pkg::ENTRY1_COUNT_RST;
      cfg.count[2] <= scp_pkg::ENTRY2_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        scp_pkg::REG_ENTRY0_NAME:  cfg.name[0]  <= cfg_data;
        scp_pkg::REG_ENTRY0_COUNT: cfg.count[0] <= cfg_data[scp_pkg::CNT_W-1:0];
        scp_pkg::REG_ENTRY1_NAME:  cfg.name[1]  <= cfg_data;
        scp_pkg::REG_ENTRY1_COUNT: cfg.count[1] <= cfg_data[scp_pkg::CNT_W-1:0];
        scp_pkg::REG_ENTRY2_NAME:  cfg.name[2]  <= cfg_data;
        scp_pkg::REG_ENTRY2_COUNT: cfg.count[2] <= cfg_data[scp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold a line end while the previous result is still waiting
  assign advance  = buf_valid && (!term || !out_valid || out_ready);
  assign in_ready = !buf_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_ready) begin
      buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      buf_byte <= rx_byte;
  end

  scp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (buf_byte),
    .term    (term),
    .line    (line)
  );

  scp_match u_match (
    .cfg           (cfg),
    .line          (line),
    .status        (match_status),
    .command_index (match_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term) begin
      status         <= match_status;
      command_index  <= match_index;
      argument_total <= line.total;
      out_args       <= line.args;
    end
  end

  assign arg0 = out_args[0];
  assign arg1 = out_args[1];
  assign arg2 = out_args[2];
  assign arg3 = out_args[3];
  assign arg4 = out_args[4];
  assign arg5 = out_args[5];
  assign arg6 = out_args[6];
  assign arg7 = out_args[7];

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (buf_valid && term && out_valid && !out_ready))
    else $error("input stalled without a blocked line end");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == scp_pkg::ST_UNKNOWN)) |-> (command_index == '0))
    else $error("unknown command with nonzero index");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (argument_total <= scp_pkg::CNT_W'(scp_pkg::ARG_LIMIT)))
    else $error("argument count beyond limit");

  assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(advance && term)) |=> !out_valid)
    else $error("result raised without a line end");
`endif

endmodule
